### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define PRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### src/prs_pkg.sv
// ----------------------------------------------------------------------------
// Power rail sequencer package
// Request and result types, configuration, rail bits, phase and blink codes
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

    // configuration register indexes
    localparam logic CFG_GOOD_TIMEOUT   = 1'b0;
    localparam logic CFG_SHUTDOWN_DELAY = 1'b1;

    localparam int CNT_W   = 24;
    localparam int TO_W    = 16;
    localparam int RAIL_W  = 13;
    localparam int PHASE_W = 4;
    localparam int FLASH_W = 3;

    localparam logic [TO_W-1:0]  GOOD_TIMEOUT_RST   = 16'd1000;
    localparam logic [CNT_W-1:0] SHUTDOWN_DELAY_RST = 24'd10000;

    // rail bit positions
    localparam int RB_3V3    = 0;
    localparam int RB_SMBUS  = 1;
    localparam int RB_RADIO  = 2;
    localparam int RB_CODEC  = 3;
    localparam int RB_CAMERA = 4;
    localparam int RB_COM3V3 = 5;
    localparam int RB_12V    = 6;
    localparam int RB_PWROK  = 7;
    localparam int RB_5V     = 8;
    localparam int RB_MOTOR  = 9;
    localparam int RB_ALLPAY = 10;
    localparam int RB_PAY1   = 11;
    localparam int RB_PAY2   = 12;

    // rails raised once 3.3V is up, and rails dropped by shutdown
    localparam logic [RAIL_W-1:0] LOADS_12V_MASK = 13'h007E;
    localparam logic [RAIL_W-1:0] MAIN_MASK      = 13'h03FF;

    // sequencing phases
    localparam logic [PHASE_W-1:0] PH_WAIT      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_W3V3      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_W12V      = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WS5       = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WS3       = 4'd4;
    localparam logic [PHASE_W-1:0] PH_W5V       = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RUN       = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SHUTDELAY = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SUSPENDED = 4'd8;

    // blink codes
    localparam logic [FLASH_W-1:0] FL_NONE     = 3'd0;
    localparam logic [FLASH_W-1:0] FL_BOOT_OK  = 3'd2;
    localparam logic [FLASH_W-1:0] FL_TO_5V    = 3'd3;
    localparam logic [FLASH_W-1:0] FL_TO_S3    = 3'd4;
    localparam logic [FLASH_W-1:0] FL_TO_S5    = 3'd5;
    localparam logic [FLASH_W-1:0] FL_TO_12V   = 3'd6;
    localparam logic [FLASH_W-1:0] FL_TO_3V3   = 3'd7;

    typedef struct packed {
        logic ext_button;
        logic pg_3v3;
        logic pg_12v;
        logic v5_good;
        logic s5_asserted;
        logic s3_asserted;
        logic pay1_det;
        logic pay2_det;
        logic shutdown_request;
        logic suspend_request;
    } t_tick_req;

    typedef struct packed {
        logic [RAIL_W-1:0]  rail_enables;
        logic [PHASE_W-1:0] phase;
        logic [FLASH_W-1:0] flash_code;
        logic               press_button;
    } t_tick_res;

    typedef struct packed {
        logic [TO_W-1:0]  good_timeout_ticks;
        logic [CNT_W-1:0] shutdown_delay_ticks;
    } t_cfg;

endpackage

`default_nettype wire

### src/prs_in_if.sv
// ----------------------------------------------------------------------------
// Tick request channel
// Valid/ready channel carrying one sample of board signals
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_in_if
    import prs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_tick_req item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### src/prs_out_if.sv
// ----------------------------------------------------------------------------
// Tick result channel
// Valid/ready channel carrying rails, phase, blink code and button pulse
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_out_if
    import prs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_tick_res item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### src/prs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_cfg_if
    import prs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             index;
    logic [CNT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/prs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the wait timeout and the shutdown delay, written over the cfg channel
// ----------------------------------------------------------------------------
`default_nettype none

module prs_cfg_regs
    import prs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    prs_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    logic [TO_W-1:0]  r_good_timeout;
    logic [CNT_W-1:0] r_shutdown_delay;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_timeout   <= GOOD_TIMEOUT_RST;
            r_shutdown_delay <= SHUTDOWN_DELAY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GOOD_TIMEOUT:   r_good_timeout   <= i_cfg.data[TO_W-1:0];
                CFG_SHUTDOWN_DELAY: r_shutdown_delay <= i_cfg.data;
                default:            r_good_timeout   <= r_good_timeout;
            endcase
        end
    end

    assign o_cfg.good_timeout_ticks   = r_good_timeout;
    assign o_cfg.shutdown_delay_ticks = r_shutdown_delay;

endmodule

`default_nettype wire

### src/prs_seq_core.sv
// ----------------------------------------------------------------------------
// Sequencer core
// Phase, wait counter and rail register, with the per-tick next-state logic
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module prs_seq_core
    import prs_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_adv,
    input  t_tick_req  i_req,
    input  t_cfg       i_cfg,
    output t_tick_res  o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [RAIL_W-1:0]  r_rails, n_rails;
    logic [FLASH_W-1:0] flash;
    logic               press;
    logic               good;
    logic               cnt_zero;
    logic               wait_done;
    logic               wait_to;
    logic [CNT_W-1:0]   cnt_load;
    logic [CNT_W-1:0]   cnt_dec;

    // signal checked by the current wait
    always_comb begin
        case (r_phase)
            PH_W3V3: good = i_req.pg_3v3;
            PH_W12V: good = i_req.pg_12v;
            PH_WS5:  good = !i_req.s5_asserted;
            PH_WS3:  good = !i_req.s3_asserted;
            PH_W5V:  good = i_req.v5_good;
            default: good = 1'b0;
        endcase
    end

    assign cnt_zero  = (r_cnt == '0);
    assign wait_done = good || cnt_zero;
    assign wait_to   = !good && cnt_zero;
    assign cnt_load  = {{(CNT_W-TO_W){1'b0}}, i_cfg.good_timeout_ticks};
    assign cnt_dec   = r_cnt - {{(CNT_W-1){1'b0}}, 1'b1};

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_rails = r_rails;
        flash   = FL_NONE;
        press   = 1'b0;
        case (r_phase)
            PH_WAIT: begin
                if (i_req.ext_button) begin
                    n_rails[RB_3V3] = 1'b1;
                    n_cnt           = cnt_load;
                    n_phase         = PH_W3V3;
                end
            end
            PH_W3V3: begin
                if (wait_done) begin
                    n_rails = r_rails | LOADS_12V_MASK;
                    flash   = wait_to ? FL_TO_3V3 : FL_NONE;
                    n_cnt   = cnt_load;
                    n_phase = PH_W12V;
                end else begin
                    n_cnt = cnt_dec;
                end
            end
            PH_W12V: begin
                if (wait_done) begin
                    n_rails[RB_PWROK] = 1'b1;
                    flash             = wait_to ? FL_TO_12V : FL_NONE;
                    n_cnt             = cnt_load;
                    n_phase           = PH_WS5;
                end else begin
                    n_cnt = cnt_dec;
                end
            end
            PH_WS5: begin
                if (wait_done) begin
                    flash   = wait_to ? FL_TO_S5 : FL_NONE;
                    press   = wait_to;
                    n_cnt   = cnt_load;
                    n_phase = PH_WS3;
                end else begin
                    n_cnt = cnt_dec;
                end
            end
            PH_WS3: begin
                if (wait_done) begin
                    n_rails[RB_5V] = 1'b1;
                    flash          = wait_to ? FL_TO_S3 : FL_NONE;
                    press          = wait_to;
                    n_cnt          = cnt_load;
                    n_phase        = PH_W5V;
                end else begin
                    n_cnt = cnt_dec;
                end
            end
            PH_W5V: begin
                if (wait_done) begin
                    n_rails[RB_MOTOR] = 1'b1;
                    flash             = wait_to ? FL_TO_5V : FL_BOOT_OK;
                    n_phase           = PH_RUN;
                end else begin
                    n_cnt = cnt_dec;
                end
            end
            PH_RUN: begin
                if (i_req.shutdown_request) begin
                    n_cnt   = i_cfg.shutdown_delay_ticks;
                    n_phase = PH_SHUTDELAY;
                end else if (i_req.suspend_request) begin
                    n_phase = PH_SUSPENDED;
                end else begin
                    n_rails[RB_ALLPAY] = i_req.pay1_det || i_req.pay2_det;
                    n_rails[RB_PAY1]   = r_rails[RB_PAY1] || i_req.pay1_det;
                    n_rails[RB_PAY2]   = r_rails[RB_PAY2] || i_req.pay2_det;
                end
            end
            PH_SHUTDELAY: begin
                if (cnt_zero) begin
                    n_rails = r_rails & ~MAIN_MASK;
                    n_phase = PH_WAIT;
                end else begin
                    n_cnt = cnt_dec;
                end
            end
            PH_SUSPENDED: begin
                n_phase = PH_SUSPENDED;
            end
            default: begin
                n_rails = '0;
                n_phase = PH_WAIT;
            end
        endcase
    end

    // state registers, moved once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_cnt   <= '0;
            r_rails <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_rails <= n_rails;
        end
    end

    assign o_res.rail_enables = n_rails;
    assign o_res.phase        = n_phase;
    assign o_res.flash_code   = flash;
    assign o_res.press_button = press;

    // button pulse only comes with an S5 or S3 timeout code
    `PRS_ASSERT(a_press_code, press |-> (flash == FL_TO_S5 || flash == FL_TO_S3), "press without S5/S3 timeout")
    // motor rail is never on without 5V
    `PRS_ASSERT(a_motor_5v, r_rails[RB_MOTOR] |-> r_rails[RB_5V], "motor rail without 5V rail")
    // suspended is held until reset
    `PRS_ASSERT(a_susp_hold, (r_phase == PH_SUSPENDED) |=> (r_phase == PH_SUSPENDED), "left suspended phase")
    // state only moves on an advance
    `PRS_ASSERT(a_state_hold, !i_adv |=> ($stable(r_phase) && $stable(r_cnt) && $stable(r_rails)), "state moved without advance")
    // reset clears the phase
    `PRS_ASSERT_ALWAYS(a_rst_phase, !i_rst_n |=> (r_phase == PH_WAIT), "phase not cleared by reset")

endmodule

`default_nettype wire

### src/power_rail_sequencer_core.sv
// ----------------------------------------------------------------------------
// Power rail sequencer
// Button-started rail bring-up, run-time payload rails and delayed shutdown
// ----------------------------------------------------------------------------
// One tick request is taken every clock cycle while the result side is ready,
// and each gives exactly one result. A request is first captured in an input
// register; when it advances, the sequencer's next-state logic (one 24-bit
// decrement and compare) updates phase, wait counter and rail register and
// loads the result register, which offers the result. While a result waits
// to be taken the input register can still take one more request; after
// that the request side stalls until the result is taken. Configuration
// writes are taken in every cycle and are meant to be issued while the
// block is idle.
`default_nettype none

module power_rail_sequencer_core
    import prs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    prs_in_if.sink    i_in_req,
    prs_out_if.source o_res,
    prs_cfg_if.sink   i_cfg
);

    logic      r_in_valid;
    t_tick_req r_in_req;
    logic      r_out_valid;
    t_tick_res r_out_res;
    logic      adv;
    t_cfg      cfg;
    t_tick_res core_res;

    // a held request moves on when the result register is free or draining
    assign adv             = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in_req.ready  = !r_in_valid || adv;

    prs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    prs_seq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_req   (r_in_req),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_req.ready) begin
            r_in_valid <= i_in_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_req.valid && i_in_req.ready) begin
            r_in_req <= i_in_req.item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res <= core_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.item  = r_out_res;

endmodule

`default_nettype wire

### dv/power_rail_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// Power rail sequencer testbench
// Drives board-signal ticks through the request channel under random
// stalls on both sides and checks every result against a cycle-free model
// of the sequencer, across several timeout and shutdown-delay settings
// ----------------------------------------------------------------------------
`default_nettype none

module power_rail_sequencer_core_tb
    import prs_pkg::*;
();

    // sequencer state as the model keeps it, configuration included
    typedef struct {
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   count;
        logic [RAIL_W-1:0]  rails;
        logic [TO_W-1:0]    good_timeout;
        logic [CNT_W-1:0]   shut_delay;
    } t_seq_state;

    localparam int IDLE_PCT = 37;

    logic i_clk;
    logic i_rst_n;

    prs_in_if  in_if();
    prs_out_if res_if();
    prs_cfg_if cfg_if();

    power_rail_sequencer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_req(in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_seq_state  seq_model;     // follows accepted requests, gives expectations
    t_seq_state  plan_model;    // follows queued requests, steers stimulus
    t_tick_req   tick_q[$];
    t_tick_res   rail_exp_q[$];
    logic        req_taken;
    logic        steady;
    int unsigned err_count;
    int unsigned ticks_taken;
    int unsigned boots_seen;
    int unsigned timeouts_seen;
    int unsigned presses_seen;

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = ~i_clk;
    end

    // one tick of the sequencer
    function automatic void step_sequencer(inout t_seq_state s, input t_tick_req r,
                                           output t_tick_res res);
        logic [FLASH_W-1:0] flash;
        logic               press;
        logic               good;
        logic               hit;
        logic               expired;
        flash   = FL_NONE;
        press   = 1'b0;
        hit     = 1'b0;
        expired = 1'b0;

        // signal checked by each wait
        case (s.phase)
            PH_W3V3: good = r.pg_3v3;
            PH_W12V: good = r.pg_12v;
            PH_WS5:  good = !r.s5_asserted;
            PH_WS3:  good = !r.s3_asserted;
            PH_W5V:  good = r.v5_good;
            default: good = 1'b0;
        endcase

        // wait leaves on good signal, times out when the counter is spent
        if (s.phase >= PH_W3V3 && s.phase <= PH_W5V) begin
            if (good) begin
                hit = 1'b1;
            end else if (s.count == '0) begin
                hit     = 1'b1;
                expired = 1'b1;
            end else begin
                s.count = s.count - 1'b1;
            end
        end

        case (s.phase)
            PH_WAIT: begin
                if (r.ext_button) begin
                    s.rails[RB_3V3] = 1'b1;
                    s.count = CNT_W'(s.good_timeout);
                    s.phase = PH_W3V3;
                end
            end
            PH_W3V3: begin
                if (hit) begin
                    s.rails = s.rails | LOADS_12V_MASK;
                    if (expired) flash = FL_TO_3V3;
                    s.count = CNT_W'(s.good_timeout);
                    s.phase = PH_W12V;
                end
            end
            PH_W12V: begin
                if (hit) begin
                    if (expired) flash = FL_TO_12V;
                    s.rails[RB_PWROK] = 1'b1;
                    s.count = CNT_W'(s.good_timeout);
                    s.phase = PH_WS5;
                end
            end
            PH_WS5: begin
                if (hit) begin
                    if (expired) begin
                        flash = FL_TO_S5;
                        press = 1'b1;
                    end
                    s.count = CNT_W'(s.good_timeout);
                    s.phase = PH_WS3;
                end
            end
            PH_WS3: begin
                if (hit) begin
                    if (expired) begin
                        flash = FL_TO_S3;
                        press = 1'b1;
                    end
                    s.rails[RB_5V] = 1'b1;
                    s.count = CNT_W'(s.good_timeout);
                    s.phase = PH_W5V;
                end
            end
            PH_W5V: begin
                if (hit) begin
                    flash = expired ? FL_TO_5V : FL_BOOT_OK;
                    s.rails[RB_MOTOR] = 1'b1;
                    s.phase = PH_RUN;
                end
            end
            PH_RUN: begin
                // shutdown wins over suspend, payload rails hold on a request tick
                if (r.shutdown_request) begin
                    s.count = s.shut_delay;
                    s.phase = PH_SHUTDELAY;
                end else if (r.suspend_request) begin
                    s.phase = PH_SUSPENDED;
                end else begin
                    s.rails[RB_ALLPAY] = r.pay1_det | r.pay2_det;
                    if (r.pay1_det) s.rails[RB_PAY1] = 1'b1;
                    if (r.pay2_det) s.rails[RB_PAY2] = 1'b1;
                end
            end
            PH_SHUTDELAY: begin
                if (s.count == '0) begin
                    s.rails = s.rails & ~MAIN_MASK;
                    s.phase = PH_WAIT;
                end else begin
                    s.count = s.count - 1'b1;
                end
            end
            PH_SUSPENDED: begin
            end
            default: begin
                s.rails = '0;
                s.phase = PH_WAIT;
            end
        endcase

        res.rail_enables = s.rails;
        res.phase        = s.phase;
        res.flash_code   = flash;
        res.press_button = press;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        $display("MISMATCH %s: got %0d expected %0d (tick %0d)",
                 what, got, want, ticks_taken);
    endtask

    // random tick shaped by the planned phase so boots get all the way through
    function automatic t_tick_req plan_tick();
        t_tick_req   r;
        int unsigned pgood;
        r     = t_tick_req'(10'($urandom()));
        pgood = (plan_model.good_timeout > 64) ? 90 : 45;
        case (plan_model.phase)
            PH_WAIT: r.ext_button  = ($urandom_range(0, 99) < 40);
            PH_W3V3: r.pg_3v3      = ($urandom_range(0, 99) < pgood);
            PH_W12V: r.pg_12v      = ($urandom_range(0, 99) < pgood);
            PH_WS5:  r.s5_asserted = !($urandom_range(0, 99) < pgood);
            PH_WS3:  r.s3_asserted = !($urandom_range(0, 99) < pgood);
            PH_W5V:  r.v5_good     = ($urandom_range(0, 99) < pgood);
            PH_RUN: begin
                // suspend is permanent, so it only rides along with shutdown here
                r.shutdown_request = (plan_model.shut_delay <= 64) &&
                                     ($urandom_range(0, 99) < 8);
                if (!r.shutdown_request) r.suspend_request = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic queue_tick(input t_tick_req r);
        t_tick_res unused;
        step_sequencer(plan_model, r, unused);
        tick_q.push_back(r);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_GOOD_TIMEOUT)
            plan_model.good_timeout = val[TO_W-1:0];
        else
            plan_model.shut_delay = val;
    endtask

    task automatic set_config(input logic [TO_W-1:0] tmo, input logic [CNT_W-1:0] dly);
        write_reg(CFG_GOOD_TIMEOUT, CNT_W'(tmo));
        write_reg(CFG_SHUTDOWN_DELAY, dly);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // hold off until every queued request has its result back
    task automatic drain_results();
        while (tick_q.size() != 0 || in_if.valid || rail_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || req_taken) begin
            if (tick_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_if.valid <= 1'b1;
                in_if.item  <= tick_q.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // predict on accepted requests and configuration writes
    always @(posedge i_clk) begin
        t_tick_res want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == CFG_GOOD_TIMEOUT)
                    seq_model.good_timeout = cfg_if.data[TO_W-1:0];
                else
                    seq_model.shut_delay = cfg_if.data;
            end
            if (in_if.valid && in_if.ready) begin
                req_taken = 1'b1;
                step_sequencer(seq_model, in_if.item, want);
                rail_exp_q.push_back(want);
                ticks_taken++;
                if (want.flash_code == FL_BOOT_OK || want.flash_code == FL_TO_5V)
                    boots_seen++;
                if (want.flash_code >= FL_TO_5V)
                    timeouts_seen++;
                if (want.press_button)
                    presses_seen++;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_tick_res want;
        t_tick_res got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.item;
            if (rail_exp_q.size() == 0) begin
                report_mismatch("result with no request waiting", 0, 0);
            end else begin
                want = rail_exp_q.pop_front();
                if (got.rail_enables !== want.rail_enables)
                    report_mismatch("rail_enables", 32'(got.rail_enables),
                                    32'(want.rail_enables));
                if (got.phase !== want.phase)
                    report_mismatch("phase", 32'(got.phase), 32'(want.phase));
                if (got.flash_code !== want.flash_code)
                    report_mismatch("flash_code", 32'(got.flash_code),
                                    32'(want.flash_code));
                if (got.press_button !== want.press_button)
                    report_mismatch("press_button", 32'(got.press_button),
                                    32'(want.press_button));
            end
        end
    end

    // run limit
    initial begin
        #8_000_000;
        $display("run limit reached with %0d results outstanding", rail_exp_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial begin
        t_tick_req   steer;
        t_tick_req   r;
        int unsigned tmo_tab[5];
        int unsigned dly_tab[5];
        int unsigned cnt_tab[5];
        int unsigned guard;

        tmo_tab = '{0, 5, 65535, 3, 2};
        dly_tab = '{0, 12, 16777215, 40, 3};
        cnt_tab = '{400, 400, 250, 450, 400};

        seq_model = '{PH_WAIT, '0, '0, GOOD_TIMEOUT_RST, SHUTDOWN_DELAY_RST};
        plan_model = seq_model;
        err_count = 0;
        ticks_taken = 0;
        boots_seen = 0;
        timeouts_seen = 0;
        presses_seen = 0;
        req_taken = 1'b0;
        steady = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.item = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_GOOD_TIMEOUT;
        cfg_if.data = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: both timeout styles on every wait, payload rails, shutdown
        set_config(16'd1, 24'd1);
        queue_tick(t_tick_req'(10'b0000000000));   // idle in wait
        queue_tick(t_tick_req'(10'b0000000011));   // requests outside run ignored
        queue_tick(t_tick_req'(10'b1000000000));   // button press
        queue_tick(t_tick_req'(10'b0011110000));   // 3.3V bad
        queue_tick(t_tick_req'(10'b0011110011));   // 3.3V times out
        queue_tick(t_tick_req'(10'b0010000000));   // 12V good
        queue_tick(t_tick_req'(10'b0000100000));   // S5 still asserted
        queue_tick(t_tick_req'(10'b0000101100));   // S5 times out, button pulse
        queue_tick(t_tick_req'(10'b0000000000));   // S3 gone
        queue_tick(t_tick_req'(10'b0000000000));   // 5V bad
        queue_tick(t_tick_req'(10'b0001000000));   // 5V good, boot done
        queue_tick(t_tick_req'(10'b0000001000));   // payload one
        queue_tick(t_tick_req'(10'b0000000100));   // payload two
        queue_tick(t_tick_req'(10'b0000000000));   // no payload
        queue_tick(t_tick_req'(10'b0000001011));   // shutdown and suspend together
        queue_tick(t_tick_req'(10'b0000000000));
        queue_tick(t_tick_req'(10'b1111111100));   // rails drop
        queue_tick(t_tick_req'(10'b1111111100));   // button again
        queue_tick(t_tick_req'(10'b1111111100));   // 3.3V good at once
        queue_tick(t_tick_req'(10'b0000000000));
        queue_tick(t_tick_req'(10'b0000000000));   // 12V times out
        queue_tick(t_tick_req'(10'b0000000000));   // S5 gone
        queue_tick(t_tick_req'(10'b0000010000));
        queue_tick(t_tick_req'(10'b0000010000));   // S3 times out
        queue_tick(t_tick_req'(10'b0000000000));
        queue_tick(t_tick_req'(10'b0000000000));   // 5V times out
        drain_results();

        // random phases, one setting each
        for (int p = 0; p < 5; p++) begin
            set_config(tmo_tab[p][TO_W-1:0], dly_tab[p][CNT_W-1:0]);
            steady = (p == 2);
            for (int k = 0; k < cnt_tab[p]; k++) begin
                queue_tick(plan_tick());
                // sender holds off mid-phase until the pipeline is empty
                if (p == 3 && k == cnt_tab[p] / 2)
                    drain_results();
            end
            drain_results();
        end
        steady = 1'b0;

        // bring the sequencer to run, then park it in suspend
        steer = '0;
        steer.ext_button = 1'b1;
        steer.pg_3v3 = 1'b1;
        steer.pg_12v = 1'b1;
        steer.v5_good = 1'b1;
        guard = 0;
        while (plan_model.phase != PH_RUN && guard < 300) begin
            queue_tick(steer);
            guard++;
        end
        r = plan_tick();
        r.shutdown_request = 1'b0;
        r.suspend_request = 1'b1;
        queue_tick(r);
        for (int k = 0; k < 10; k++)
            queue_tick(t_tick_req'(10'($urandom())));
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d ticks over 6 settings: %0d boots, %0d wait timeouts",
                 ticks_taken, boots_seen, timeouts_seen);
        $display("host button pulses %0d, final phase %0d", presses_seen, seq_model.phase);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", err_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
